### rtl/cct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camping cabin thermostat package
// Word types, field codes, register indexes and shared constants.
// ----------------------------------------------------------------------------
package cct_pkg;

    // Input word fields.
    localparam int CMD_W      = 2;
    localparam int SOC_W      = 10;
    localparam int CABIN_W    = 12;

    // Result word fields.
    localparam int REQ_W      = 2;
    localparam int REASON_W   = 3;
    localparam int NOTE_W     = 2;

    // Configuration register widths and port.
    localparam int SOC_FLOOR_W = 7;
    localparam int RUN_HOURS_W = 8;
    localparam int BAND_W      = 7;
    localparam int DWELL_W     = 16;
    localparam int SANE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // State widths.
    localparam int SESSION_W   = 20;
    localparam int CHANGE_W    = 16;

    // Signed width that holds every scaled temperature bound and the reading.
    localparam int TEMP_W      = 13;
    // Width that holds the scaled SoC floor.
    localparam int SOC_CMP_W   = 11;

    localparam logic [SESSION_W-1:0] SECS_PER_HOUR = SESSION_W'(3600);
    localparam logic [SESSION_W-1:0] SESSION_MAX   = {SESSION_W{1'b1}};
    localparam logic [CHANGE_W-1:0]  CHANGE_MAX    = {CHANGE_W{1'b1}};

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    // Climate request codes.
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

    // Exit reasons.
    localparam logic [REASON_W-1:0] EXIT_NONE       = 3'd0;
    localparam logic [REASON_W-1:0] EXIT_VEHICLE_ON = 3'd1;
    localparam logic [REASON_W-1:0] EXIT_TIME_LIMIT = 3'd2;
    localparam logic [REASON_W-1:0] EXIT_SOC_FLOOR  = 3'd3;
    localparam logic [REASON_W-1:0] EXIT_MANUAL     = 3'd4;

    // Thermostat notes.
    localparam logic [NOTE_W-1:0] NOTE_NORMAL    = 2'd0;
    localparam logic [NOTE_W-1:0] NOTE_BAND_BAD  = 2'd1;
    localparam logic [NOTE_W-1:0] NOTE_TEMP_BAD  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SOC_FLOOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_HOURS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SANE_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SANE_HIGH = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic                      vehicle_on;
        logic                      charging;
        logic [SOC_W-1:0]          soc_tenths;
        logic                      soc_stale;
        logic signed [CABIN_W-1:0] cabin_tenths;
        logic                      cabin_stale;
        logic                      hvac_running;
        logic                      command_pending;
    } in_item_t;

    typedef struct packed {
        logic [REQ_W-1:0]    clima_request;
        logic                session_active;
        logic [REASON_W-1:0] exit_reason;
        logic [NOTE_W-1:0]   thermostat_note;
    } out_item_t;

    typedef struct packed {
        logic [SOC_FLOOR_W-1:0]   soc_floor_pct;
        logic [RUN_HOURS_W-1:0]   max_run_hours;
        logic signed [BAND_W-1:0] band_low_c;
        logic signed [BAND_W-1:0] band_high_c;
        logic [DWELL_W-1:0]       min_dwell_secs;
        logic signed [SANE_W-1:0] sane_low_c;
        logic signed [SANE_W-1:0] sane_high_c;
    } cfg_t;

    // Times ten as two shifts and an add; the result fits TEMP_W for the configuration bounds passed in.
    function automatic logic signed [TEMP_W-1:0] scale10(input logic signed [TEMP_W-1:0] v);
        scale10 = (v <<< 3) + (v <<< 1);
    endfunction

endpackage

### rtl/cct_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camping cabin thermostat configuration registers
// Decodes the configuration write channel into the seven setting registers.
// ----------------------------------------------------------------------------
module cct_cfg_regs
    import cct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.soc_floor_pct  <= SOC_FLOOR_W'(30);
            cfg_reg.max_run_hours  <= RUN_HOURS_W'(8);
            cfg_reg.band_low_c     <= BAND_W'(15);
            cfg_reg.band_high_c    <= BAND_W'(26);
            cfg_reg.min_dwell_secs <= DWELL_W'(600);
            cfg_reg.sane_low_c     <= -SANE_W'(40);
            cfg_reg.sane_high_c    <= SANE_W'(80);
        end else if (cfg_valid) begin
            // Indexes past the last register are dropped.
            unique case (cfg_index)
                REG_SOC_FLOOR: cfg_reg.soc_floor_pct  <= cfg_data[SOC_FLOOR_W-1:0];
                REG_RUN_HOURS: cfg_reg.max_run_hours  <= cfg_data[RUN_HOURS_W-1:0];
                REG_BAND_LOW:  cfg_reg.band_low_c     <= cfg_data[BAND_W-1:0];
                REG_BAND_HIGH: cfg_reg.band_high_c    <= cfg_data[BAND_W-1:0];
                REG_DWELL:     cfg_reg.min_dwell_secs <= cfg_data[DWELL_W-1:0];
                REG_SANE_LOW:  cfg_reg.sane_low_c     <= cfg_data[SANE_W-1:0];
                REG_SANE_HIGH: cfg_reg.sane_high_c    <= cfg_data[SANE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/camping_cabin_thermostat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camping cabin thermostat
// Session control with exit checks and a dwell-limited bang-bang thermostat.
// Path: an accepted word is held in the input register, and its result is then registered for m_.
// Throughput: one word per cycle; the input register refills while the
// result register is being taken, so the only stall is m_ready held low.
// Reset: synchronous, active low; clears both valid flags, the session state
// and loads the default settings. The configuration port is always ready.
// ----------------------------------------------------------------------------
module camping_cabin_thermostat
    import cct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    cct_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    in_item_t              in_reg;
    logic                  in_valid_reg;
    out_item_t             m_data_reg;
    logic                  m_valid_reg;
    logic                  session_on_reg, session_on_next;
    logic [SESSION_W-1:0]  session_secs_reg, session_secs_next;
    logic [CHANGE_W-1:0]   since_change_reg, since_change_next;
    out_item_t             res_next;
    logic                  advance;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Scaled bounds and comparisons.
    logic signed [TEMP_W-1:0] cabin;
    logic signed [TEMP_W-1:0] sane_lo10, sane_hi10, band_lo10, band_hi10;
    logic                     band_bad, temp_bad, in_band;
    logic [NOTE_W-1:0]        note;
    logic [SESSION_W-1:0]     run_limit, secs_inc;
    logic [CHANGE_W-1:0]      change_inc;
    logic [SOC_CMP_W-1:0]     soc_floor10;
    logic                     soc_low;

    always_comb begin
        cabin     = TEMP_W'(in_reg.cabin_tenths);
        sane_lo10 = scale10(TEMP_W'(cfg.sane_low_c));
        sane_hi10 = scale10(TEMP_W'(cfg.sane_high_c));
        band_lo10 = scale10(TEMP_W'(cfg.band_low_c));
        band_hi10 = scale10(TEMP_W'(cfg.band_high_c));
        band_bad  = cfg.band_low_c > cfg.band_high_c;
        temp_bad  = in_reg.cabin_stale || !(cabin > sane_lo10) || !(cabin < sane_hi10);
        in_band   = (cabin >= band_lo10) && (cabin <= band_hi10);
        priority if (band_bad) begin
            note = NOTE_BAND_BAD;
        end else if (temp_bad) begin
            note = NOTE_TEMP_BAD;
        end else begin
            note = NOTE_NORMAL;
        end

        run_limit   = SESSION_W'(cfg.max_run_hours) * SECS_PER_HOUR;
        secs_inc    = (session_secs_reg == SESSION_MAX) ? session_secs_reg
                                                        : session_secs_reg + 1'b1;
        change_inc  = (since_change_reg == CHANGE_MAX) ? since_change_reg
                                                       : since_change_reg + 1'b1;
        soc_floor10 = SOC_CMP_W'(cfg.soc_floor_pct) * SOC_CMP_W'(10);
        soc_low     = !in_reg.charging && !in_reg.soc_stale
                      && (SOC_CMP_W'(in_reg.soc_tenths) <= soc_floor10);
    end

    // Next state and result for the word in the input register.
    always_comb begin
        session_on_next   = session_on_reg;
        session_secs_next = session_secs_reg;
        since_change_next = since_change_reg;
        res_next          = '0;

        unique case (in_reg.command)
            CMD_START: begin
                session_on_next   = 1'b1;
                session_secs_next = '0;
                since_change_next = cfg.min_dwell_secs;
                res_next.thermostat_note = note;
                if (note == NOTE_NORMAL && !in_reg.hvac_running && !in_band) begin
                    res_next.clima_request = REQ_START;
                    since_change_next      = '0;
                end
            end
            CMD_STOP: begin
                if (session_on_reg) begin
                    session_on_next        = 1'b0;
                    res_next.clima_request = REQ_STOP;
                    res_next.exit_reason   = EXIT_MANUAL;
                end
            end
            CMD_TICK: begin
                if (session_on_reg) begin
                    session_secs_next = secs_inc;
                    since_change_next = change_inc;
                    priority if (in_reg.vehicle_on) begin
                        res_next.exit_reason = EXIT_VEHICLE_ON;
                    end else if (secs_inc >= run_limit) begin
                        res_next.exit_reason = EXIT_TIME_LIMIT;
                    end else if (soc_low) begin
                        res_next.exit_reason = EXIT_SOC_FLOOR;
                    end else if (!in_reg.command_pending
                                 && change_inc >= cfg.min_dwell_secs) begin
                        res_next.thermostat_note = note;
                        if (note == NOTE_NORMAL) begin
                            if (in_reg.hvac_running && in_band) begin
                                res_next.clima_request = REQ_STOP;
                                since_change_next      = '0;
                            end else if (!in_reg.hvac_running && !in_band) begin
                                res_next.clima_request = REQ_START;
                                since_change_next      = '0;
                            end
                        end
                    end
                    if (res_next.exit_reason != EXIT_NONE) begin
                        session_on_next        = 1'b0;
                        res_next.clima_request = REQ_STOP;
                    end
                end
            end
            default: ;
        endcase

        res_next.session_active = session_on_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            session_on_reg   <= 1'b0;
            session_secs_reg <= '0;
            since_change_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    session_on_reg   <= session_on_next;
                    session_secs_reg <= session_secs_next;
                    since_change_reg <= since_change_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance && in_valid_reg) begin
            m_data_reg <= res_next;
        end
    end

    // An exit always asks for climate stop and leaves the session inactive.
    a_exit_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.exit_reason != EXIT_NONE
        |-> m_data.clima_request == REQ_STOP && !m_data.session_active)
        else $error("exit word without stop request or with session active");

    // A thermostat note is only given when no exit was taken and nothing requested.
    a_note_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.thermostat_note != NOTE_NORMAL
        |-> m_data.exit_reason == EXIT_NONE && m_data.clima_request == REQ_NONE)
        else $error("thermostat note together with a request or exit");

    // The session only ends when a word is processed.
    a_session_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(session_on_reg) |-> $past(advance && in_valid_reg))
        else $error("session ended without a processed word");

    // The session counter never advances while no session is running.
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(!session_on_reg) && !session_on_reg
        |-> $stable(session_secs_reg))
        else $error("session counter moved while idle");

endmodule
